### rtl/core/tlnp_pkg.sv
// Shared types and constants for the token lexer with number parse.
`default_nettype none

package tlnp_pkg;

  // Fixed widths of the result fields
  localparam int START_W  = 16;
  localparam int LENGTH_W = 16;
  localparam int MANT_W   = 48;
  localparam int FRAC_W   = 4;

  // Byte codes the scanner cares about
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // Scanner mode; code 3 is unused and treated as between tokens
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PLAIN = 2'd1,
    MODE_QUOTE = 2'd2
  } scan_mode_t;

  // Token classes as reported
  typedef enum logic [2:0] {
    CLS_NUMBER = 3'd0,
    CLS_STRING = 3'd1,
    CLS_UNDER  = 3'd2,
    CLS_PROC   = 3'd3,
    CLS_OPEN   = 3'd4
  } token_class_t;

  // Classified input byte, front to back
  typedef struct packed {
    logic [7:0] code;
    logic [3:0] digit;
    logic       is_space;
    logic       is_quote;
    logic       is_minus;
    logic       is_under;
    logic       is_point;
    logic       is_digit;
    logic       eot;
  } cmd_t;

  // One reported token
  typedef struct packed {
    token_class_t          token_class;
    logic [START_W-1:0]    content_start;
    logic [LENGTH_W-1:0]   content_length;
    logic [MANT_W-1:0]     number_mantissa;
    logic [FRAC_W-1:0]     fraction_digits;
    logic                  number_overflow;
    logic                  stream_done;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/token_lexer_with_number_parse.sv
// Top level of the token lexer with decimal number parse.
//
// Takes one text byte per cycle and reports each token as it ends: its class, content offset
// and length, and for numbers a signed decimal mantissa with a fraction digit count. Both
// sides are queues: a byte goes in when push is high and full is low; a token is read while
// empty is low and taken when pop is high. Sustained rate is one byte per clock while the
// result queue has room, set by the scanner step (mode update plus one times-ten accumulate).
// A token reaches the result ports by way of the byte queue and the result queue. The
// scanner holds while the result queue is full, so a reader that stops popping stalls the
// input once both queues fill. Offsets restart from zero after each byte marked end of text.
`default_nettype none

module token_lexer_with_number_parse #(
  parameter int OFFSET_BITS         = 16,
  parameter int MANTISSA_BITS       = 48,
  parameter int MAX_FRACTION_DIGITS = 15,
  parameter int QUEUE_DEPTH         = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_end_of_text,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       out_token_class,
  output logic [15:0]      out_content_start,
  output logic [15:0]      out_content_length,
  output logic [47:0]      out_number_mantissa,
  output logic [3:0]       out_fraction_digits,
  output logic             out_number_overflow,
  output logic             out_stream_done
);

  localparam int CMD_W = $bits(tlnp_pkg::cmd_t);
  localparam int RES_W = $bits(tlnp_pkg::result_t);

  tlnp_pkg::cmd_t    cmd_in, cmd_out;
  tlnp_pkg::result_t res_in, res_out;
  logic              cmdq_full, cmdq_push, cmdq_empty, cmd_take;
  logic              resq_full, res_push;

  // Front end: classify bytes
  tlnp_front u_front (
    .push        (push),
    .full        (full),
    .char_code   (in_char_code),
    .end_of_text (in_end_of_text),
    .q_full      (cmdq_full),
    .q_push      (cmdq_push),
    .cmd         (cmd_in)
  );

  // Queue between front and back
  tlnp_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmdq_push),
    .wr_data (cmd_in),
    .full    (cmdq_full),
    .pop     (cmd_take),
    .rd_data (cmd_out),
    .empty   (cmdq_empty)
  );

  // Back end: scanner and number accumulator
  tlnp_back #(
    .OFFSET_BITS         (OFFSET_BITS),
    .MANTISSA_BITS       (MANTISSA_BITS),
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmdq_empty),
    .cmd       (cmd_out),
    .cmd_take  (cmd_take),
    .res_room  (!resq_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue feeding the output ports
  tlnp_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_in),
    .full    (resq_full),
    .pop     (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign out_token_class     = res_out.token_class;
  assign out_content_start   = res_out.content_start;
  assign out_content_length  = res_out.content_length;
  assign out_number_mantissa = res_out.number_mantissa;
  assign out_fraction_digits = res_out.fraction_digits;
  assign out_number_overflow = res_out.number_overflow;
  assign out_stream_done     = res_out.stream_done;

endmodule

`default_nettype wire

### rtl/core/tlnp_fifo.sv
// Small register queue used between the front, the back and the result port.
`default_nettype none

module tlnp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and fill count updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tlnp_front.sv
// Front end: takes input bytes and classifies them for the scanner.
`default_nettype none

module tlnp_front (
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  char_code,
  input  wire logic        end_of_text,
  input  wire logic        q_full,
  output logic             q_push,
  output tlnp_pkg::cmd_t   cmd
);

  logic digit_hit;

  assign full   = q_full;
  assign q_push = push && !q_full;

  assign digit_hit = (char_code >= tlnp_pkg::CH_ZERO) && (char_code <= tlnp_pkg::CH_NINE);

  // Byte classification
  always_comb begin
    cmd.code     = char_code;
    cmd.is_digit = digit_hit;
    cmd.digit    = digit_hit ? 4'(char_code - tlnp_pkg::CH_ZERO) : 4'd0;
    cmd.is_space = (char_code == tlnp_pkg::CH_SPACE) || (char_code == tlnp_pkg::CH_NEWLINE);
    cmd.is_quote = (char_code == tlnp_pkg::CH_DQUOTE) || (char_code == tlnp_pkg::CH_SQUOTE);
    cmd.is_minus = (char_code == tlnp_pkg::CH_MINUS);
    cmd.is_under = (char_code == tlnp_pkg::CH_UNDER);
    cmd.is_point = (char_code == tlnp_pkg::CH_POINT);
    cmd.eot      = end_of_text;
  end

endmodule

`default_nettype wire

### rtl/core/tlnp_back.sv
// Back end: token scanner, decimal accumulator and token report.
`default_nettype none

module tlnp_back #(
  parameter int OFFSET_BITS         = 16,
  parameter int MANTISSA_BITS       = 48,
  parameter int MAX_FRACTION_DIGITS = 15
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cmd_valid,
  input  wire tlnp_pkg::cmd_t   cmd,
  output logic                  cmd_take,
  input  wire logic             res_room,
  output logic                  res_push,
  output tlnp_pkg::result_t     res
);

  localparam int ACC_W  = MANTISSA_BITS - 1;
  localparam int PROD_W = ACC_W + 4;
  localparam int OW = (OFFSET_BITS > tlnp_pkg::START_W) ? OFFSET_BITS : tlnp_pkg::START_W;
  localparam int MW = (MANTISSA_BITS > tlnp_pkg::MANT_W) ? MANTISSA_BITS : tlnp_pkg::MANT_W;
  localparam logic [ACC_W-1:0] ACC_LIM = {ACC_W{1'b1}};
  localparam logic [tlnp_pkg::FRAC_W-1:0] FRAC_LIM = tlnp_pkg::FRAC_W'(MAX_FRACTION_DIGITS);

  tlnp_pkg::scan_mode_t   mode_r, mode_nxt, mode_scan;
  logic [7:0]             quote_r, quote_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic [OFFSET_BITS-1:0] begin_r, begin_nxt;
  tlnp_pkg::token_class_t cls_r, cls_nxt;
  logic                   neg_r, neg_nxt;
  logic                   point_r, point_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [tlnp_pkg::FRAC_W-1:0] frac_r, frac_nxt;
  logic                   ovf_r, ovf_nxt;

  logic                   step;
  logic                   starting;
  logic                   base_point, base_ovf;
  logic [ACC_W-1:0]       base_acc;
  logic [tlnp_pkg::FRAC_W-1:0] base_frac;
  logic                   dig_point, dig_ovf;
  logic [ACC_W-1:0]       dig_acc;
  logic [tlnp_pkg::FRAC_W-1:0] dig_frac;
  logic [PROD_W-1:0]      prod;
  logic                   emit_space, emit_string, eot_plain, eot_open;
  logic [OFFSET_BITS-1:0] end_pos, plain_len;
  logic                   plain_num;
  logic [MW-1:0]          mant_wide;

  // Offset to the 16-bit report width
  function automatic logic [tlnp_pkg::START_W-1:0] to_port(input logic [OFFSET_BITS-1:0] v);
    logic [OW-1:0] w;
    w = OW'(v);
    return w[tlnp_pkg::START_W-1:0];
  endfunction

  assign step     = cmd_valid && res_room;
  assign cmd_take = step;
  assign starting = (mode_r != tlnp_pkg::MODE_PLAIN) && (mode_r != tlnp_pkg::MODE_QUOTE)
                    && !cmd.is_space;

  // One decimal digit step; a fresh token starts from a cleared accumulator
  always_comb begin
    base_point = starting ? 1'b0 : point_r;
    base_ovf   = starting ? 1'b0 : ovf_r;
    base_acc   = starting ? '0 : acc_r;
    base_frac  = starting ? '0 : frac_r;
    prod = (PROD_W'(base_acc) << 3) + (PROD_W'(base_acc) << 1) + PROD_W'(cmd.digit);
    dig_point = base_point;
    dig_ovf   = base_ovf;
    dig_acc   = base_acc;
    dig_frac  = base_frac;
    if (cmd.is_point && !base_point) begin
      dig_point = 1'b1;
    end else if (!(base_point && (base_frac >= FRAC_LIM))) begin
      if (base_point) begin
        dig_frac = base_frac + 1'b1;
      end
      if (base_ovf || (prod > PROD_W'(ACC_LIM))) begin
        dig_acc = ACC_LIM;
        dig_ovf = 1'b1;
      end else begin
        dig_acc = prod[ACC_W-1:0];
      end
    end
  end

  // Scanner next state
  always_comb begin
    mode_scan   = mode_r;
    quote_nxt   = quote_r;
    begin_nxt   = begin_r;
    cls_nxt     = cls_r;
    neg_nxt     = neg_r;
    point_nxt   = point_r;
    acc_nxt     = acc_r;
    frac_nxt    = frac_r;
    ovf_nxt     = ovf_r;
    emit_space  = 1'b0;
    emit_string = 1'b0;
    unique case (mode_r)
      tlnp_pkg::MODE_PLAIN: begin
        if (cmd.is_space) begin
          emit_space = 1'b1;
          mode_scan  = tlnp_pkg::MODE_IDLE;
        end else begin
          point_nxt = dig_point;
          acc_nxt   = dig_acc;
          frac_nxt  = dig_frac;
          ovf_nxt   = dig_ovf;
        end
      end
      tlnp_pkg::MODE_QUOTE: begin
        if (cmd.code == quote_r) begin
          emit_string = 1'b1;
          mode_scan   = tlnp_pkg::MODE_IDLE;
        end
      end
      default: begin
        if (starting) begin
          begin_nxt = offset_r;
          neg_nxt   = 1'b0;
          point_nxt = 1'b0;
          acc_nxt   = '0;
          frac_nxt  = '0;
          ovf_nxt   = 1'b0;
          if (cmd.is_quote) begin
            mode_scan = tlnp_pkg::MODE_QUOTE;
            quote_nxt = cmd.code;
            cls_nxt   = tlnp_pkg::CLS_STRING;
          end else begin
            mode_scan = tlnp_pkg::MODE_PLAIN;
            priority if (cmd.is_under) begin
              cls_nxt = tlnp_pkg::CLS_UNDER;
            end else if (cmd.is_minus) begin
              cls_nxt = tlnp_pkg::CLS_NUMBER;
              neg_nxt = 1'b1;
            end else if (cmd.is_digit) begin
              cls_nxt   = tlnp_pkg::CLS_NUMBER;
              point_nxt = dig_point;
              acc_nxt   = dig_acc;
              frac_nxt  = dig_frac;
              ovf_nxt   = dig_ovf;
            end else begin
              cls_nxt = tlnp_pkg::CLS_PROC;
            end
          end
        end
      end
    endcase
    // End of text closes everything and rewinds the offset
    if (cmd.eot) begin
      mode_nxt   = tlnp_pkg::MODE_IDLE;
      offset_nxt = '0;
    end else begin
      mode_nxt   = mode_scan;
      offset_nxt = offset_r + 1'b1;
    end
  end

  // Token report
  assign eot_plain = cmd.eot && (mode_scan == tlnp_pkg::MODE_PLAIN);
  assign eot_open  = cmd.eot && (mode_scan == tlnp_pkg::MODE_QUOTE);
  assign end_pos   = emit_space ? offset_r : offset_r + 1'b1;
  assign plain_len = end_pos - begin_nxt;
  assign plain_num = (cls_nxt == tlnp_pkg::CLS_NUMBER)
                     && !(neg_nxt && (plain_len == OFFSET_BITS'(1)));
  assign mant_wide = neg_nxt ? (~MW'(acc_nxt) + 1'b1) : MW'(acc_nxt);

  always_comb begin
    res.token_class     = tlnp_pkg::CLS_PROC;
    res.content_start   = to_port(begin_nxt);
    res.content_length  = to_port(plain_len);
    res.number_mantissa = '0;
    res.fraction_digits = '0;
    res.number_overflow = 1'b0;
    res.stream_done     = cmd.eot;
    priority if (emit_space || eot_plain) begin
      if (plain_num) begin
        res.token_class     = tlnp_pkg::CLS_NUMBER;
        res.number_mantissa = mant_wide[tlnp_pkg::MANT_W-1:0];
        res.fraction_digits = frac_nxt;
        res.number_overflow = ovf_nxt;
      end else if (cls_nxt == tlnp_pkg::CLS_UNDER) begin
        res.token_class    = tlnp_pkg::CLS_UNDER;
        res.content_start  = to_port(begin_nxt + 1'b1);
        res.content_length = to_port(plain_len - 1'b1);
      end else if (cls_nxt == tlnp_pkg::CLS_NUMBER) begin
        // a lone minus sign is a procedure name
        res.token_class = tlnp_pkg::CLS_PROC;
      end else begin
        res.token_class = cls_nxt;
      end
    end else if (emit_string) begin
      res.token_class    = tlnp_pkg::CLS_STRING;
      res.content_start  = to_port(begin_r + 1'b1);
      res.content_length = to_port(offset_r - begin_r - 1'b1);
    end else begin
      res.token_class    = tlnp_pkg::CLS_OPEN;
      res.content_start  = to_port(begin_nxt + 1'b1);
      res.content_length = '0;
    end
  end

  assign res_push = step && (emit_space || emit_string || eot_plain || eot_open);

  // Scanner registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= tlnp_pkg::MODE_IDLE;
      quote_r  <= tlnp_pkg::CH_DQUOTE;
      offset_r <= '0;
      begin_r  <= '0;
      cls_r    <= tlnp_pkg::CLS_NUMBER;
      neg_r    <= 1'b0;
      point_r  <= 1'b0;
      acc_r    <= '0;
      frac_r   <= '0;
      ovf_r    <= 1'b0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      quote_r  <= quote_nxt;
      offset_r <= offset_nxt;
      begin_r  <= begin_nxt;
      cls_r    <= cls_nxt;
      neg_r    <= neg_nxt;
      point_r  <= point_nxt;
      acc_r    <= acc_nxt;
      frac_r   <= frac_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

`ifndef SYNTH
  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (acc_r == ACC_LIM))
    else $error("overflow flag set without saturated mantissa");
  a_frac_limit: assert property (@(posedge clk) disable iff (!rst_n)
    frac_r <= FRAC_LIM)
    else $error("fraction digit count beyond limit");
  a_frac_needs_point: assert property (@(posedge clk) disable iff (!rst_n)
    (frac_r != '0) |-> point_r)
    else $error("fraction digits counted before decimal point");
  a_eot_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (step && cmd.eot) |=> ((offset_r == '0) && (mode_r == tlnp_pkg::MODE_IDLE)))
    else $error("scanner not rewound after end of text");
`endif

endmodule

`default_nettype wire

### dv/token_lexer_with_number_parse_tb.sv
// Self-checking testbench for the token lexer with decimal number parse.
`default_nettype none

module token_lexer_with_number_parse_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_FRAC     = 15;
  localparam int ITEM_TARGET  = 800;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1000000;

  // Scoreboard: lexer predictor plus the queue of tokens still owed
  class token_scoreboard;
    tlnp_pkg::scan_mode_t   mode;
    logic [7:0]             quote;
    logic [15:0]            offset;
    logic [15:0]            tok_start;
    tlnp_pkg::token_class_t lead_class;
    bit                     negative;
    bit                     point;
    logic [63:0]            mant;
    logic [3:0]             frac;
    bit                     ovf;
    tlnp_pkg::result_t      owed_q[$];
    int                     errors;

    function void clear();
      mode       = tlnp_pkg::MODE_IDLE;
      quote      = tlnp_pkg::CH_DQUOTE;
      offset     = '0;
      tok_start  = '0;
      lead_class = tlnp_pkg::CLS_NUMBER;
      negative   = 0;
      point      = 0;
      mant       = '0;
      frac       = '0;
      ovf        = 0;
      owed_q.delete();
      errors     = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] ERROR %s", $realtime, msg);
      errors++;
    endtask

    // One byte of a number: first point marks the fraction, non-digits count as zero
    function void add_digit(logic [7:0] c);
      logic [63:0] d;
      logic [63:0] lim;
      d   = (c >= tlnp_pkg::CH_ZERO && c <= tlnp_pkg::CH_NINE) ?
            64'(c - tlnp_pkg::CH_ZERO) : 64'd0;
      lim = (64'd1 << (tlnp_pkg::MANT_W - 1)) - 64'd1;
      if (c == tlnp_pkg::CH_POINT && !point) begin
        point = 1;
        return;
      end
      if (point) begin
        if (frac >= MAX_FRAC) return;
        frac++;
      end
      if (ovf || mant > (lim - d) / 64'd10) begin
        mant = lim;
        ovf  = 1;
      end else begin
        mant = mant * 64'd10 + d;
      end
    endfunction

    function tlnp_pkg::result_t make_token(tlnp_pkg::token_class_t cls, logic [15:0] st,
                                           logic [15:0] len, logic [47:0] m,
                                           logic [3:0] f, bit o);
      tlnp_pkg::result_t r;
      r.token_class     = cls;
      r.content_start   = st;
      r.content_length  = len;
      r.number_mantissa = m;
      r.fraction_digits = f;
      r.number_overflow = o;
      r.stream_done     = 0;
      return r;
    endfunction

    // Token that ends on whitespace or end of text
    function tlnp_pkg::result_t plain_token(logic [15:0] stop);
      logic [15:0]            len;
      tlnp_pkg::token_class_t cls;
      len = stop - tok_start;
      cls = lead_class;
      if (cls == tlnp_pkg::CLS_NUMBER && negative && len == 16'd1) cls = tlnp_pkg::CLS_PROC;
      if (cls == tlnp_pkg::CLS_NUMBER)
        return make_token(cls, tok_start, len,
                          negative ? 48'd0 - mant[47:0] : mant[47:0], frac, ovf);
      if (cls == tlnp_pkg::CLS_UNDER)
        return make_token(cls, tok_start + 16'd1, len - 16'd1, '0, '0, 0);
      return make_token(cls, tok_start, len, '0, '0, 0);
    endfunction

    // Accepted input byte: advance the predictor, owe a token if one ends
    function void note_byte(logic [7:0] c, bit eot);
      logic [15:0]       pos;
      bit                ws;
      bit                got;
      tlnp_pkg::result_t r;
      pos = offset;
      ws  = (c == tlnp_pkg::CH_SPACE || c == tlnp_pkg::CH_NEWLINE);
      got = 0;
      case (mode)
        tlnp_pkg::MODE_PLAIN: begin
          if (ws) begin
            r    = plain_token(pos);
            got  = 1;
            mode = tlnp_pkg::MODE_IDLE;
          end else begin
            add_digit(c);
          end
        end
        tlnp_pkg::MODE_QUOTE: begin
          if (c == quote) begin
            r    = make_token(tlnp_pkg::CLS_STRING, tok_start + 16'd1,
                              pos - tok_start - 16'd1, '0, '0, 0);
            got  = 1;
            mode = tlnp_pkg::MODE_IDLE;
          end
        end
        default: begin
          if (!ws) begin
            tok_start = pos;
            negative  = 0;
            point     = 0;
            mant      = '0;
            frac      = '0;
            ovf       = 0;
            if (c == tlnp_pkg::CH_DQUOTE || c == tlnp_pkg::CH_SQUOTE) begin
              mode       = tlnp_pkg::MODE_QUOTE;
              quote      = c;
              lead_class = tlnp_pkg::CLS_STRING;
            end else begin
              mode = tlnp_pkg::MODE_PLAIN;
              if (c == tlnp_pkg::CH_UNDER) begin
                lead_class = tlnp_pkg::CLS_UNDER;
              end else if (c == tlnp_pkg::CH_MINUS) begin
                lead_class = tlnp_pkg::CLS_NUMBER;
                negative   = 1;
              end else if (c >= tlnp_pkg::CH_ZERO && c <= tlnp_pkg::CH_NINE) begin
                lead_class = tlnp_pkg::CLS_NUMBER;
                add_digit(c);
              end else begin
                lead_class = tlnp_pkg::CLS_PROC;
              end
            end
          end
        end
      endcase

      if (eot) begin
        if (mode == tlnp_pkg::MODE_PLAIN) begin
          r   = plain_token(pos + 16'd1);
          got = 1;
        end else if (mode == tlnp_pkg::MODE_QUOTE) begin
          r   = make_token(tlnp_pkg::CLS_OPEN, tok_start + 16'd1, '0, '0, '0, 0);
          got = 1;
        end
        if (got) r.stream_done = 1;
        mode   = tlnp_pkg::MODE_IDLE;
        offset = '0;
      end else begin
        offset = pos + 16'd1;
      end
      if (got) owed_q.push_back(r);
    endfunction

    task check_field(string name, logic [63:0] got, logic [63:0] exp);
      if (got !== exp)
        report($sformatf("%s got 0x%0h expected 0x%0h", name, got, exp));
    endtask

    // Accepted token: compare with the oldest one owed
    task check_token(tlnp_pkg::result_t got);
      tlnp_pkg::result_t exp;
      if (owed_q.size() == 0) begin
        report($sformatf("token with no prediction, class %0d start %0d",
                         got.token_class, got.content_start));
        return;
      end
      exp = owed_q.pop_front();
      check_field("token_class", 64'(got.token_class), 64'(exp.token_class));
      check_field("content_start", 64'(got.content_start), 64'(exp.content_start));
      check_field("content_length", 64'(got.content_length), 64'(exp.content_length));
      check_field("number_mantissa", 64'(got.number_mantissa), 64'(exp.number_mantissa));
      check_field("fraction_digits", 64'(got.fraction_digits), 64'(exp.fraction_digits));
      check_field("number_overflow", 64'(got.number_overflow), 64'(exp.number_overflow));
      check_field("stream_done", 64'(got.stream_done), 64'(exp.stream_done));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_char_code;
  logic        in_end_of_text;
  logic        empty;
  logic        pop;
  logic [2:0]  out_token_class;
  logic [15:0] out_content_start;
  logic [15:0] out_content_length;
  logic [47:0] out_number_mantissa;
  logic [3:0]  out_fraction_digits;
  logic        out_number_overflow;
  logic        out_stream_done;

  token_scoreboard sb;
  int              bytes_sent;
  bit              idle_on;
  int              hold_requests;
  int              holds_done;
  int              stall_left;
  bit              pop_idle_on;
  logic [7:0]      text_q[$];

  token_lexer_with_number_parse DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_char_code       (in_char_code),
    .in_end_of_text     (in_end_of_text),
    .empty              (empty),
    .pop                (pop),
    .out_token_class    (out_token_class),
    .out_content_start  (out_content_start),
    .out_content_length (out_content_length),
    .out_number_mantissa(out_number_mantissa),
    .out_fraction_digits(out_fraction_digits),
    .out_number_overflow(out_number_overflow),
    .out_stream_done    (out_stream_done)
  );

  // Clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Known values on every input from time zero
  initial begin
    rst_n          = 1'b0;
    push           = 1'b0;
    pop            = 1'b0;
    in_char_code   = '0;
    in_end_of_text = 1'b0;
    hold_requests  = 0;
    holds_done     = 0;
    stall_left     = 0;
    pop_idle_on    = 1'b1;
    idle_on        = 1'b1;
    bytes_sent     = 0;
    sb             = new();
    sb.clear();
  end

  // Monitor: note accepted bytes, check accepted tokens
  always @(posedge clk) begin : monitor
    tlnp_pkg::result_t got;
    if (rst_n) begin
      if (push && !full) sb.note_byte(in_char_code, in_end_of_text);
      if (pop && !empty) begin
        got.token_class     = tlnp_pkg::token_class_t'(out_token_class);
        got.content_start   = out_content_start;
        got.content_length  = out_content_length;
        got.number_mantissa = out_number_mantissa;
        got.fraction_digits = out_fraction_digits;
        got.number_overflow = out_number_overflow;
        got.stream_done     = out_stream_done;
        sb.check_token(got);
      end
    end
  end

  // Token reader: random stalls, long holds on request
  always @(posedge clk) begin : pop_driver
    int r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 299) == 0) pop_idle_on <= ~pop_idle_on;
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      pop        <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (holds_done != hold_requests) begin
      pop        <= 1'b0;
      holds_done <= holds_done + 1;
      stall_left <= HOLD_CYCLES;
    end else if (pop_idle_on && r < 10) begin
      pop        <= 1'b0;
      stall_left <= (r < 8) ? $urandom_range(0, 3) : $urandom_range(20, 60);
    end else begin
      pop <= 1'b1;
    end
  end

  // Gap after a byte: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(logic [7:0] c, bit eot);
    int gap;
    in_char_code   <= c;
    in_end_of_text <= eot;
    push           <= 1'b1;
    do @(posedge clk); while (full);
    bytes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_string(string s, bit eot_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], eot_last && (i == s.len() - 1));
  endtask

  task automatic send_queued_text();
    for (int i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // Stop offering bytes and wait for every owed token
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Byte that starts a procedure name
  function automatic logic [7:0] proc_lead();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == tlnp_pkg::CH_SPACE || c == tlnp_pkg::CH_NEWLINE ||
           c == tlnp_pkg::CH_SQUOTE || c == tlnp_pkg::CH_DQUOTE ||
           c == tlnp_pkg::CH_UNDER || c == tlnp_pkg::CH_MINUS ||
           (c >= tlnp_pkg::CH_ZERO && c <= tlnp_pkg::CH_NINE));
    return c;
  endfunction

  function automatic void add_separator();
    int n;
    n = $urandom_range(1, 3);
    repeat (n)
      text_q.push_back($urandom_range(0, 1) ? tlnp_pkg::CH_SPACE : tlnp_pkg::CH_NEWLINE);
  endfunction

  function automatic void add_quoted(bit close);
    logic [7:0] q;
    logic [7:0] c;
    int         n;
    q = $urandom_range(0, 1) ? tlnp_pkg::CH_SQUOTE : tlnp_pkg::CH_DQUOTE;
    n = $urandom_range(0, 6);
    text_q.push_back(q);
    repeat (n) begin
      do c = 8'($urandom_range(0, 255)); while (c == q);
      text_q.push_back(c);
    end
    if (close) text_q.push_back(q);
  endfunction

  // One well-formed text of random tokens, ending in one of several ways
  function automatic void build_text();
    int ntok;
    int n;
    bit last_quoted;
    ntok = $urandom_range(1, 8);
    if ($urandom_range(0, 4) == 0) add_separator();
    for (int t = 0; t < ntok; t++) begin
      last_quoted = 0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if ($urandom_range(0, 19) == 0) begin
            text_q.push_back(tlnp_pkg::CH_MINUS);
          end else begin
            if ($urandom_range(0, 1)) text_q.push_back(tlnp_pkg::CH_MINUS);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 5);
            repeat (n) text_q.push_back(tlnp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 2) == 0) begin
              text_q.push_back(tlnp_pkg::CH_POINT);
              n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 18) : $urandom_range(0, 4);
              repeat (n) text_q.push_back(tlnp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 9) == 0) text_q.push_back(proc_lead());
            if ($urandom_range(0, 9) == 0) text_q.push_back(tlnp_pkg::CH_POINT);
          end
        end
        4, 5: begin
          add_quoted(1);
          last_quoted = 1;
        end
        6: begin
          text_q.push_back(tlnp_pkg::CH_UNDER);
          n = $urandom_range(0, 5);
          repeat (n) text_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end
        default: begin
          text_q.push_back(proc_lead());
          n = $urandom_range(0, 5);
          repeat (n) text_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end
      endcase
      if (t < ntok - 1 && !(last_quoted && $urandom_range(0, 2) == 0)) add_separator();
    end
    case ($urandom_range(0, 3))
      0: add_separator();
      1: begin
        add_separator();
        add_quoted(0);
      end
      default: ;
    endcase
  endfunction

  // Text of arbitrary bytes
  function automatic void n_noise();
    int n;
    n = $urandom_range(1, 20);
    repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Stimulus
  initial begin : stimulus
    int texts;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every class, back-to-back strings, lone minus, second point,
    // end on whitespace, unterminated quote, whitespace-only text, end inside a token
    send_string("-12.3 - _ab 'x'\"y\" 1.2.a\n", 1);
    send_string("'ab", 1);
    send_string(" ", 1);
    send_string("9", 1);
    wait_drained();

    // Random texts, with the pressure points along the way
    texts = 0;
    while (bytes_sent < ITEM_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        n_noise();
      end else begin
        build_text();
      end
      send_queued_text();
      texts++;

      if (texts == 6) begin
        // Reader holds off while a dense text is offered, so the input stalls
        idle_on = 0;
        hold_requests++;
        for (int i = 0; i < 40; i++) begin
          text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
          text_q.push_back(tlnp_pkg::CH_SPACE);
        end
        send_queued_text();
      end
      if (texts == 12) wait_drained();
    end

    // Drain and finish
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/core/tlnp_pkg.sv
rtl/core/tlnp_fifo.sv
rtl/core/tlnp_front.sv
rtl/core/tlnp_back.sv
rtl/core/token_lexer_with_number_parse.sv
dv/token_lexer_with_number_parse_tb.sv
